FILE: rtl/core/wsam_pkg.sv
// Shared constants, operation codes and cell control type for the wide multiplier.
package wsam_pkg;

   localparam int A_WORDS_DEF   = 10;
   localparam int B_WORDS_DEF   = 5;
   localparam int WORD_BITS_DEF = 32;

   // Fixed field widths of the request and response transactions.
   localparam int OP_W  = 2;
   localparam int IDX_W = 4;
   localparam int VAL_W = 32;

   localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
   localparam logic [OP_W-1:0] OP_START  = 2'd2;

   typedef struct packed {
      logic clear;
      logic step;
      logic add;
      logic shift_out;
   } cell_ctl_type;

endpackage

FILE: rtl/core/wsam_if.sv
// Valid/ready channel interfaces for the request and response transactions.
interface wsam_req_if import wsam_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  operation;
   logic [IDX_W-1:0] word_index;
   logic [VAL_W-1:0] word_value;

   modport source (output valid, output operation, output word_index, output word_value,
                   input ready);
   modport sink   (input valid, input operation, input word_index, input word_value,
                   output ready);
endinterface

interface wsam_rsp_if import wsam_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] product_word;
   logic [IDX_W-1:0] product_index;
   logic             last_word;

   modport source (output valid, output product_word, output product_index,
                   output last_word, input ready);
   modport sink   (input valid, input product_word, input product_index,
                   input last_word, output ready);
endinterface

FILE: rtl/core/wsam_cell.sv
// One word cell of the chain: multiplicand word, product word and pending carry.
module wsam_cell import wsam_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                 clock,
   input  cell_ctl_type         ctl,
   input  logic [WORD_BITS-1:0] load_word,
   input  logic                 bit_low,
   input  logic                 carry_low,
   input  logic [WORD_BITS-1:0] sum_low,
   output logic                 bit_out,
   output logic                 carry_out,
   output logic [WORD_BITS-1:0] sum_out
);

   logic [WORD_BITS-1:0] mcand_ff, mcand_in;
   logic [WORD_BITS-1:0] sum_ff, sum_in;
   logic                 carry_ff, carry_in;
   logic [WORD_BITS-1:0] addend;
   logic [WORD_BITS:0]   add_result;

   // The carry out of this word is registered and added by the upper neighbor in the next
   // cycle, so the accumulator stays in carry-save form until the flush cycles.
   assign addend     = ctl.add ? mcand_ff : '0;
   assign add_result = {1'b0, sum_ff} + {1'b0, addend} + (WORD_BITS + 1)'(carry_low);

   always_comb begin
      mcand_in = mcand_ff;
      sum_in   = sum_ff;
      carry_in = carry_ff;
      priority if (ctl.clear) begin
         mcand_in = load_word;
         sum_in   = '0;
         carry_in = 1'b0;
      end else if (ctl.step) begin
         mcand_in = {mcand_ff[WORD_BITS-2:0], bit_low};
         sum_in   = add_result[WORD_BITS-1:0];
         carry_in = add_result[WORD_BITS];
      end else if (ctl.shift_out) begin
         sum_in = sum_low;
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      sum_ff   <= sum_in;
      carry_ff <= carry_in;
   end

   assign bit_out   = mcand_ff[WORD_BITS-1];
   assign carry_out = carry_ff;
   assign sum_out   = sum_ff;

endmodule

FILE: rtl/core/wide_shift_add_multiplier.sv
// Top level of the shift-and-add multiplier built from a chain of word cells.
// The block stays ready during loads. A start runs B_WORDS*WORD_BITS shift-and-add
// steps and then flushes the pending carries through the chain. After the flush the
// product words follow one per cycle while the sink is ready, and the next transaction
// is accepted once the last product word is registered.
// Synchronous active-high reset clears control state and both operand stores to zero.
module wide_shift_add_multiplier import wsam_pkg::*; #(
   parameter int A_WORDS   = A_WORDS_DEF,
   parameter int B_WORDS   = B_WORDS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input logic          clock,
   input logic          reset,
   wsam_req_if.sink     req_chan,
   wsam_rsp_if.source   rsp_chan
);

   localparam int P_WORDS   = A_WORDS + B_WORDS;
   localparam int MUL_STEPS = B_WORDS * WORD_BITS;
   localparam int CNT_MAX   = (MUL_STEPS > P_WORDS) ? MUL_STEPS : P_WORDS;
   localparam int CNT_W     = $clog2(CNT_MAX);
   localparam int EIDX_W    = $clog2(P_WORDS);
   localparam int AIDX_W    = (A_WORDS > 1) ? $clog2(A_WORDS) : 1;
   localparam int BIDX_W    = (B_WORDS > 1) ? $clog2(B_WORDS) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MUL   = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [EIDX_W-1:0]    eidx_ff, eidx_in;
   logic [MUL_STEPS-1:0] mplier_sr_ff, mplier_sr_in;
   logic [MUL_STEPS-1:0] mplier_flat;

   logic [WORD_BITS-1:0] mcand_mem_ff [A_WORDS];
   logic [WORD_BITS-1:0] mplier_mem_ff [B_WORDS];

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]     rsp_word_ff;
   logic [IDX_W-1:0]     rsp_index_ff;
   logic                 rsp_last_ff;

   logic                 req_accept;
   logic                 start_accept;
   logic                 emit_go;
   logic                 emit_last;
   logic [WORD_BITS-1:0] val_w;
   cell_ctl_type         ctl;

   // Chains between neighbors; entry P_WORDS is the constant feed below the last cell.
   logic                 bit_chain   [P_WORDS+1];
   logic                 carry_chain [P_WORDS+1];
   logic [WORD_BITS-1:0] sum_chain   [P_WORDS+1];

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign start_accept   = req_accept && (req_chan.operation == OP_START);
   assign val_w          = WORD_BITS'(req_chan.word_value);
   assign emit_go        = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);
   assign emit_last      = (eidx_ff == EIDX_W'(P_WORDS - 1));

   always_comb begin
      ctl.clear     = start_accept;
      ctl.step      = (state_ff == ST_MUL) || (state_ff == ST_FLUSH);
      ctl.add       = (state_ff == ST_MUL) && mplier_sr_ff[0];
      ctl.shift_out = emit_go;
   end

   // Operand stores.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < A_WORDS; i++) begin
            mcand_mem_ff[i] <= '0;
         end
         for (int i = 0; i < B_WORDS; i++) begin
            mplier_mem_ff[i] <= '0;
         end
      end else if (req_accept) begin
         if (req_chan.operation == OP_LOAD_A && 32'(req_chan.word_index) < A_WORDS) begin
            mcand_mem_ff[AIDX_W'(req_chan.word_index)] <= val_w;
         end
         if (req_chan.operation == OP_LOAD_B && 32'(req_chan.word_index) < B_WORDS) begin
            mplier_mem_ff[BIDX_W'(req_chan.word_index)] <= val_w;
         end
      end
   end

   // Word 0 is most significant, so the last word lands in the low bits.
   always_comb begin
      for (int b = 0; b < B_WORDS; b++) begin
         mplier_flat[(B_WORDS-1-b)*WORD_BITS +: WORD_BITS] = mplier_mem_ff[b];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      eidx_in      = eidx_ff;
      mplier_sr_in = mplier_sr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_accept) begin
               state_in     = ST_MUL;
               cnt_in       = CNT_W'(MUL_STEPS - 1);
               mplier_sr_in = mplier_flat;
            end
         end
         ST_MUL: begin
            mplier_sr_in = mplier_sr_ff >> 1;
            if (cnt_ff == '0) begin
               state_in = ST_FLUSH;
               cnt_in   = CNT_W'(P_WORDS - 1);
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_FLUSH: begin
            if (cnt_ff == '0) begin
               state_in = ST_EMIT;
               eidx_in  = '0;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               eidx_in = eidx_ff + 1'b1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff       <= cnt_in;
      eidx_ff      <= eidx_in;
      mplier_sr_ff <= mplier_sr_in;
   end

   // Response register.
   assign rsp_valid_in = emit_go ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit_go) begin
         rsp_word_ff  <= VAL_W'(sum_chain[0]);
         rsp_index_ff <= IDX_W'(eidx_ff);
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.product_word  = rsp_word_ff;
   assign rsp_chan.product_index = rsp_index_ff;
   assign rsp_chan.last_word     = rsp_last_ff;

   // Cell chain; cell 0 holds the most significant word.
   assign bit_chain[P_WORDS]   = 1'b0;
   assign carry_chain[P_WORDS] = 1'b0;
   assign sum_chain[P_WORDS]   = '0;

   for (genvar i = 0; i < P_WORDS; i++) begin : g_cell
      logic [WORD_BITS-1:0] load_word;
      if (i < B_WORDS) begin : g_zero
         assign load_word = '0;
      end else begin : g_mcand
         assign load_word = mcand_mem_ff[i - B_WORDS];
      end

      wsam_cell #(
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_word (load_word),
         .bit_low   (bit_chain[i+1]),
         .carry_low (carry_chain[i+1]),
         .sum_low   (sum_chain[i+1]),
         .bit_out   (bit_chain[i]),
         .carry_out (carry_chain[i]),
         .sum_out   (sum_chain[i])
      );
   end

endmodule

FILE: rtl/core/wsam_checker.sv
// Port-level checker for the wide multiplier, bound to the top level.
module wsam_checker import wsam_pkg::*; #(
   parameter int A_WORDS = A_WORDS_DEF,
   parameter int B_WORDS = B_WORDS_DEF
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic [OP_W-1:0]  req_operation,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [VAL_W-1:0] rsp_product_word,
   input logic [IDX_W-1:0] rsp_product_index,
   input logic             rsp_last_word
);

   localparam int P_WORDS = A_WORDS + B_WORDS;

   // A stalled response transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_product_word)
         && $stable(rsp_product_index) && $stable(rsp_last_word))
      else $error("stalled response changed");

   // The final word of a run carries the lowest product position.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_word |-> rsp_product_index == IDX_W'(P_WORDS - 1))
      else $error("last word at wrong index");

   // A start transaction occupies the block.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_START |=> !req_ready)
      else $error("ready after start");

   // Loads never block the request channel.
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_LOAD_A || req_operation == OP_LOAD_B)
         |=> req_ready)
      else $error("load blocked the request channel");

endmodule

bind wide_shift_add_multiplier wsam_checker #(
   .A_WORDS (A_WORDS),
   .B_WORDS (B_WORDS)
) u_wsam_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_operation     (req_chan.operation),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_product_word  (rsp_chan.product_word),
   .rsp_product_index (rsp_chan.product_index),
   .rsp_last_word     (rsp_chan.last_word)
);
